### src/pkc_pkg.sv
// shared types, constants and the exponential table of the kernel correlation unit
package pkc_pkg;

    localparam int COORD_W = 16;
    localparam int SUM_W   = 32;
    localparam int CNT_W   = 16;
    localparam int EXP_W   = 16;
    localparam int DIFF_W  = 18;
    localparam int SQ_W    = 34;
    localparam int DIST_W  = 36;
    localparam int SIG_W   = 16;
    localparam int PROD_W  = DIST_W + SIG_W;
    localparam int IDX_SH  = 28;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_NBR   = 2'd1;
    localparam logic [1:0] ACT_EMPTY = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] REG_KERNELS = 2'd0;
    localparam logic [1:0] REG_POINTS  = 2'd1;
    localparam logic [1:0] REG_INV_SIG = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_NBR,
        CMD_EMPTY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic [3:0]                slot;
        logic [3:0]                pt;
        logic [2:0][COORD_W-1:0]   a;
        logic [2:0][COORD_W-1:0]   b;
        logic                      last;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic last_pt;
        logic last_all;
    } tag_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_RD,
        ST_LD,
        ST_DIV,
        ST_OUT
    } seq_state_t;

    typedef logic [EXP_W-1:0] exp_tab_t [256];

    function automatic exp_tab_t build_exp_table();
        exp_tab_t   t;
        logic [63:0] e;
        logic [63:0] r;
        e = 64'd1 << 32;
        for (int i = 0; i < 256; i++) begin
            r = (e + (64'd1 << 19)) >> 20;
            t[i] = r[EXP_W-1:0];
            e = (e * 64'd4034748382 + (64'd1 << 31)) >> 32;
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

### src/point_kernel_correlation_unit.sv
// top level of the point kernel correlation unit
//
// channel   dir  handshake           payload
// s_        in   s_tvalid/s_tready   tdata: slot, point, coord a 0..2, coord b 0..2;
//                                    tuser: action; tlast: last neighbour
// m_        out  m_tvalid/m_tready   tdata: kernel index, correlation; tlast: last result
// cfg_      in   cfg_wr_en           cfg_index, cfg_wdata
//
// a neighbour is issued against every kernel point in ST_RUN, then drains the pipeline
// each result after the last neighbour comes from the 32-step serial divider
// a centre without neighbours gives one result a cycle while m_tready is high
// reset is synchronous; the kernel store holds no reset value and needs no clearing pass
// a 4-entry command queue lets input continue while results wait at m_tready
module point_kernel_correlation_unit
    import pkc_pkg::*;
#(
    parameter int MAX_KERNELS = 16,
    parameter int MAX_POINTS  = 16,
    parameter int DIM         = 3
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // kernel_slot, kernel_point, coord_a_0..2, coord_b_0..2
    input  logic [1:0]   s_tuser,   // action
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // kernel_index, correlation
    output logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    pkc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    pkc_back #(
        .MAX_KERNELS (MAX_KERNELS),
        .MAX_POINTS  (MAX_POINTS),
        .DIM         (DIM)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

### src/pkc_front.sv
// input side: takes items, sorts out their kind and queues them as commands; items with no action are dropped
module pkc_front
    import pkc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // kernel_slot, kernel_point, coord_a_0..2, coord_b_0..2
    input  logic [1:0]   s_tuser,   // action
    input  logic         s_tlast,
    output cmd_t         cmd,
    output logic         cmd_valid,
    input  logic         cmd_pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t               queue_mem [QUEUE_DEPTH];
    logic [PW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]        fill_reg, fill_next;
    cmd_t               in_cmd;
    logic               push;

    always_comb begin
        in_cmd.slot = s_tdata[3:0];
        in_cmd.pt   = s_tdata[7:4];
        in_cmd.a[0] = s_tdata[23:8];
        in_cmd.a[1] = s_tdata[39:24];
        in_cmd.a[2] = s_tdata[55:40];
        in_cmd.b[0] = s_tdata[71:56];
        in_cmd.b[1] = s_tdata[87:72];
        in_cmd.b[2] = s_tdata[103:88];
        in_cmd.last = s_tlast;
        case (s_tuser)
            ACT_LOAD:  in_cmd.kind = CMD_LOAD;
            ACT_NBR:   in_cmd.kind = CMD_NBR;
            default:   in_cmd.kind = CMD_EMPTY;
        endcase
    end

    assign s_tready  = fill_reg < (PW+1)'(QUEUE_DEPTH);
    assign push      = s_tvalid && s_tready && (s_tuser != ACT_NONE);
    assign cmd_valid = fill_reg != '0;
    assign cmd       = queue_mem[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !(cmd_pop && cmd_valid)) begin
            fill_next = fill_reg + 1'b1;
        end else if (!push && cmd_pop && cmd_valid) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (cmd_pop && cmd_valid) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### src/pkc_back.sv
// work side: kernel store, distance pipeline, accumulators, divider and result register
module pkc_back
    import pkc_pkg::*;
#(
    parameter int MAX_KERNELS = 16,
    parameter int MAX_POINTS  = 16,
    parameter int DIM         = 3
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  cmd_t         cmd,
    input  logic         cmd_valid,
    output logic         cmd_pop,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,
    output logic         m_tlast
);

    localparam int KB  = (MAX_KERNELS > 1) ? $clog2(MAX_KERNELS) : 1;
    localparam int PB  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NKW = $clog2(MAX_KERNELS + 1);
    localparam int NPW = $clog2(MAX_POINTS + 1);
    localparam int AW  = KB + PB;

    logic [4:0]        kiu_reg, ppk_reg;
    logic [SIG_W-1:0]  inv_sig_reg;
    logic [NKW-1:0]    nk;
    logic [NPW-1:0]    np;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kiu_reg     <= 5'd16;
            ppk_reg     <= 5'd16;
            inv_sig_reg <= 16'd256;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_KERNELS: kiu_reg     <= cfg_wdata[4:0];
                REG_POINTS:  ppk_reg     <= cfg_wdata[4:0];
                REG_INV_SIG: inv_sig_reg <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    always_comb begin
        if (kiu_reg == '0) nk = NKW'(1);
        else if (32'(kiu_reg) > MAX_KERNELS) nk = NKW'(MAX_KERNELS);
        else nk = NKW'(kiu_reg);
        if (ppk_reg == '0) np = NPW'(1);
        else if (32'(ppk_reg) > MAX_POINTS) np = NPW'(MAX_POINTS);
        else np = NPW'(ppk_reg);
    end

    // sequencer
    seq_state_t        state_reg, state_next;
    logic [KB-1:0]     l_reg, l_next;
    logic [PB-1:0]     i_reg, i_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [(2**KB)-1:0] live_reg, live_next;
    logic              zero_reg, zero_next;
    logic [SUM_W-1:0]  div_q_reg, div_q_next;
    logic [CNT_W:0]    div_r_reg, div_r_next;
    logic [4:0]        div_cnt_reg, div_cnt_next;
    logic              mv_reg, mv_next;
    logic [3:0]        mk_reg, mk_next;
    logic [15:0]       mc_reg, mc_next;
    logic              ml_reg, ml_next;

    logic              issue, st_we, sum_rd_en;
    logic [KB-1:0]     sum_rd_addr;
    logic [AW-1:0]     st_waddr;
    logic              l_is_last, i_is_last, out_free;
    logic [CNT_W:0]    r_sh;
    logic              done6;
    logic [31:0]       l_ext, slot_ext, pt_ext;

    // pipeline
    logic [6:1]          vld_reg;
    tag_t                tag_reg    [1:6];
    logic [KB-1:0]       lp_reg     [1:6];
    logic [COORD_W*DIM-1:0] krow_reg;
    logic signed [DIFF_W-1:0] v_reg [DIM];
    logic [SQ_W-1:0]     sq_reg     [DIM];
    logic [DIST_W-1:0]   dist_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [7:0]          idx_reg;
    logic [SUM_W-1:0]    sum_rd_reg, acc_reg, acc_next;
    logic [SUM_W:0]      acc_sum;
    logic [DIST_W-1:0]   dist_sum;

    logic [COORD_W*DIM-1:0] store_mem [2**AW];
    logic [SUM_W-1:0]       sums_mem  [2**KB];

    assign l_ext     = 32'(l_reg);
    assign slot_ext  = 32'(cmd.slot);
    assign pt_ext    = 32'(cmd.pt);
    assign st_waddr  = {slot_ext[KB-1:0], pt_ext[PB-1:0]};
    assign l_is_last = l_ext == 32'(nk) - 32'd1;
    assign i_is_last = 32'(i_reg) == 32'(np) - 32'd1;
    assign out_free  = !mv_reg || m_tready;
    assign r_sh      = {div_r_reg[CNT_W-1:0], div_q_reg[SUM_W-1]};
    assign done6     = vld_reg[6] && tag_reg[6].last_all;

    always_comb begin
        state_next   = state_reg;
        l_next       = l_reg;
        i_next       = i_reg;
        count_next   = count_reg;
        live_next    = live_reg;
        zero_next    = zero_reg;
        div_q_next   = div_q_reg;
        div_r_next   = div_r_reg;
        div_cnt_next = div_cnt_reg;
        mv_next      = mv_reg && !m_tready;
        mk_next      = mk_reg;
        mc_next      = mc_reg;
        ml_next      = ml_reg;
        issue        = 1'b0;
        st_we        = 1'b0;
        cmd_pop      = 1'b0;
        sum_rd_en    = vld_reg[5] && tag_reg[5].first;
        sum_rd_addr  = lp_reg[5];
        // a kernel sum holds data of this centre once its first neighbour wrote it
        if (vld_reg[6] && tag_reg[6].last_pt) live_next[lp_reg[6]] = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.kind)
                        CMD_LOAD: begin
                            cmd_pop = 1'b1;
                            st_we   = (slot_ext < MAX_KERNELS) && (pt_ext < MAX_POINTS);
                        end
                        CMD_NBR: begin
                            l_next     = '0;
                            i_next     = '0;
                            state_next = ST_RUN;
                        end
                        default: begin
                            cmd_pop    = 1'b1;
                            count_next = '0;
                            live_next  = '0;
                            zero_next  = 1'b1;
                            l_next     = '0;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                issue = 1'b1;
                if (i_is_last) begin
                    i_next = '0;
                    if (l_is_last) state_next = ST_DRAIN;
                    else l_next = l_reg + 1'b1;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (done6) begin
                    cmd_pop = 1'b1;
                    if (count_reg != '1) count_next = count_reg + 1'b1;
                    if (cmd.last) begin
                        zero_next  = 1'b0;
                        l_next     = '0;
                        state_next = ST_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RD: begin
                sum_rd_en   = 1'b1;
                sum_rd_addr = l_reg;
                state_next  = ST_LD;
            end
            ST_LD: begin
                div_q_next   = live_reg[l_reg] ? sum_rd_reg : '0;
                div_r_next   = '0;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                if (r_sh >= {1'b0, count_reg}) begin
                    div_r_next = r_sh - {1'b0, count_reg};
                    div_q_next = {div_q_reg[SUM_W-2:0], 1'b1};
                end else begin
                    div_r_next = r_sh;
                    div_q_next = {div_q_reg[SUM_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == '1) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    mk_next = l_ext[3:0];
                    ml_next = l_is_last;
                    if (zero_reg) mc_next = '0;
                    else if (|div_q_reg[SUM_W-1:16]) mc_next = '1;
                    else mc_next = div_q_reg[15:0];
                    if (l_is_last) begin
                        count_next = '0;
                        live_next  = '0;
                        state_next = ST_IDLE;
                    end else begin
                        l_next     = l_reg + 1'b1;
                        state_next = zero_reg ? ST_OUT : ST_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            live_reg  <= '0;
            mv_reg    <= 1'b0;
            vld_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            live_reg  <= live_next;
            mv_reg    <= mv_next;
            vld_reg   <= {vld_reg[5:1], issue};
        end
    end

    always_ff @(posedge aclk) begin
        l_reg       <= l_next;
        i_reg       <= i_next;
        zero_reg    <= zero_next;
        div_q_reg   <= div_q_next;
        div_r_reg   <= div_r_next;
        div_cnt_reg <= div_cnt_next;
        mk_reg      <= mk_next;
        mc_reg      <= mc_next;
        ml_reg      <= ml_next;
    end

    // kernel store
    always_ff @(posedge aclk) begin
        if (st_we) begin
            for (int d = 0; d < DIM; d++) begin
                store_mem[st_waddr][d*COORD_W +: COORD_W] <= cmd.a[d];
            end
        end
        if (issue) begin
            krow_reg <= store_mem[{l_reg, i_reg}];
        end
    end

    // distance pipeline
    always_comb begin
        dist_sum = '0;
        for (int d = 0; d < DIM; d++) begin
            dist_sum = dist_sum + DIST_W'(sq_reg[d]);
        end
        acc_sum  = {1'b0, (tag_reg[6].first ? (live_reg[lp_reg[6]] ? sum_rd_reg : '0)
                                            : acc_reg)} + (SUM_W+1)'(EXP_TABLE[idx_reg]);
        acc_next = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        logic signed [2*DIFF_W-1:0] sq;
        tag_reg[1].first    <= i_reg == '0;
        tag_reg[1].last_pt  <= i_is_last;
        tag_reg[1].last_all <= i_is_last && l_is_last;
        lp_reg[1]           <= l_reg;
        for (int s = 2; s <= 6; s++) begin
            tag_reg[s] <= tag_reg[s-1];
            lp_reg[s]  <= lp_reg[s-1];
        end
        for (int d = 0; d < DIM; d++) begin
            v_reg[d] <= DIFF_W'($signed(krow_reg[d*COORD_W +: COORD_W]))
                      + DIFF_W'($signed(cmd.a[d])) - DIFF_W'($signed(cmd.b[d]));
            sq = v_reg[d] * v_reg[d];
            sq_reg[d] <= sq[SQ_W-1:0];
        end
        dist_reg <= dist_sum;
        prod_reg <= PROD_W'(dist_reg) * PROD_W'(inv_sig_reg);
        idx_reg  <= (|prod_reg[PROD_W-1:IDX_SH+8]) ? 8'hFF : prod_reg[IDX_SH+7:IDX_SH];
        if (vld_reg[6]) begin
            acc_reg <= acc_next;
        end
    end

    // kernel accumulators
    always_ff @(posedge aclk) begin
        if (sum_rd_en) begin
            sum_rd_reg <= sums_mem[sum_rd_addr];
        end
        if (vld_reg[6] && tag_reg[6].last_pt) begin
            sums_mem[lp_reg[6]] <= acc_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {4'b0, mc_reg, mk_reg};
    assign m_tlast  = ml_reg;

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (count_reg != '0))
        else $error("divide with zero neighbour count");
    a_drain_end: assert property (@(posedge aclk) disable iff (!aresetn)
        done6 |-> (state_reg == ST_DRAIN))
        else $error("last evaluation outside drain");
    a_run_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (cmd_valid && cmd.kind == CMD_NBR))
        else $error("neighbour command lost during run");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !out_free) |=> (state_reg == ST_OUT))
        else $error("result sequencing moved while output blocked");

endmodule
